[sv/smrc_pkg.sv]
// Shared types, keyword table and codes for the message reassembly classifier.
// Used by smrc_feed, smrc_out_buf and ship_message_reassembly_classifier.
// No dependencies.
package smrc_pkg;

  // message size limit and the width of the byte counter that reaches it
  localparam int MAX_MESSAGE_BYTES = 8192;
  localparam int CNT_W             = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int LEN_W             = 13;

  localparam logic [7:0] QUOTE_CHAR = 8'h22;

  // message type codes
  localparam logic [7:0] TYPE_DATA_A    = 8'd1;
  localparam logic [7:0] TYPE_DATA_B    = 8'd2;
  localparam logic [7:0] TYPE_TERMINATE = 8'd3;

  // key position saturates here
  localparam logic [4:0] KEY_POS_MAX = 5'd31;

  // message classes
  localparam logic [2:0] CLS_NONE       = 3'd0;
  localparam logic [2:0] CLS_TERMINATE  = 3'd1;
  localparam logic [2:0] CLS_HELLO      = 3'd2;
  localparam logic [2:0] CLS_PIN_STATE  = 3'd3;
  localparam logic [2:0] CLS_ACCESS_REQ = 3'd4;
  localparam logic [2:0] CLS_ACCESS_MTH = 3'd5;
  localparam logic [2:0] CLS_DATA       = 3'd6;
  localparam logic [2:0] CLS_UNKNOWN    = 3'd7;

  // beat status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // keyword table, text right-aligned in a packed vector
  localparam int NUM_KW     = 6;
  localparam int KW_MAX_LEN = 20;
  localparam int KW_BITS    = KW_MAX_LEN * 8;

  localparam logic [KW_BITS-1:0] KW_STR [NUM_KW] = '{
    KW_BITS'("connectionHello"),
    KW_BITS'("connectionPinState"),
    KW_BITS'("messageHello"),
    KW_BITS'("accessMethodsRequest"),
    KW_BITS'("accessMethods"),
    KW_BITS'("data")
  };
  localparam logic [4:0] KW_LEN [NUM_KW] = '{5'd15, 5'd18, 5'd12, 5'd20, 5'd13, 5'd4};
  localparam logic [2:0] KW_CLASS [NUM_KW] = '{
    CLS_HELLO, CLS_PIN_STATE, CLS_HELLO, CLS_ACCESS_REQ, CLS_ACCESS_MTH, CLS_DATA
  };

  // key scanner phase
  typedef enum logic [1:0] {
    KP_SEEK   = 2'd0,
    KP_IN_KEY = 2'd1,
    KP_CLOSED = 2'd2
  } key_phase_t;

  // running state of the message being assembled
  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic             oversize;
    logic [7:0]       type_byte;
    logic [7:0]       head_byte;
    key_phase_t       phase;
    logic [4:0]       pos;
    logic [NUM_KW-1:0] mask;
  } msg_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    logic       message_final;
  } in_beat_t;

  typedef struct packed {
    logic             status;
    logic [2:0]       message_class;
    logic [7:0]       message_type;
    logic [7:0]       cmi_head;
    logic [LEN_W-1:0] message_length;
  } out_beat_t;

  // character of keyword k at position pos (first character is position 0)
  function automatic logic [7:0] kw_byte(input int k, input logic [4:0] pos);
    logic [4:0]         idx;
    logic [KW_BITS-1:0] sh;
    idx = KW_LEN[k] - pos - 5'd1;
    sh  = KW_STR[k] >> {idx, 3'b000};
    return sh[7:0];
  endfunction

endpackage

[sv/smrc_feed.sv]
// One payload byte into the message state: type and head capture, byte count,
// size limit and one step of the quoted-key matcher. Depends on smrc_pkg.
module smrc_feed (
  input  smrc_pkg::msg_state_t cur,
  input  logic [7:0]           data_byte,
  output smrc_pkg::msg_state_t nxt
);
  import smrc_pkg::*;

  logic [CNT_W-1:0] total_inc;

  assign total_inc = cur.total + CNT_W'(1);

  always_comb begin
    nxt          = cur;
    nxt.total    = total_inc;
    // limit reached once the count hits the maximum
    if (total_inc >= CNT_W'(MAX_MESSAGE_BYTES)) begin
      nxt.oversize = 1'b1;
    end
    if (cur.total == '0) begin
      nxt.type_byte = data_byte;
    end else begin
      if (cur.total == CNT_W'(1)) begin
        nxt.head_byte = data_byte;
      end
      // key scan over bytes after the type
      case (cur.phase)
        KP_SEEK: begin
          if (data_byte == QUOTE_CHAR) begin
            nxt.phase = KP_IN_KEY;
            nxt.pos   = '0;
            nxt.mask  = '1;
          end
        end
        KP_IN_KEY: begin
          if (data_byte == QUOTE_CHAR) begin
            nxt.phase = KP_CLOSED;
          end else begin
            for (int k = 0; k < NUM_KW; k++) begin
              if (!(cur.pos < KW_LEN[k] && kw_byte(k, cur.pos) == data_byte)) begin
                nxt.mask[k] = 1'b0;
              end
            end
            if (cur.pos != KEY_POS_MAX) begin
              nxt.pos = cur.pos + 5'd1;
            end
          end
        end
        default: begin
          nxt.phase = cur.phase;
        end
      endcase
    end
  end

endmodule

[sv/smrc_out_buf.sv]
// Two-entry result buffer so the input side keeps moving while a result
// beat waits at the output. Depends on smrc_pkg.
module smrc_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  smrc_pkg::out_beat_t push_data,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output smrc_pkg::out_beat_t out_data
);
  import smrc_pkg::*;

  out_beat_t  entry0;
  out_beat_t  entry1;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = entry0;
  assign space     = (count != 2'd2);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // entry shuffle, oldest beat always in entry0
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        entry0 <= push_data;
      end else begin
        entry0 <= entry1;
      end
      if (push && count == 2'd2) begin
        entry1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        entry0 <= push_data;
      end else begin
        entry1 <= push_data;
      end
    end
  end

endmodule

[sv/ship_message_reassembly_classifier.sv]
// Top level of the message reassembly classifier: frame tracking, message
// state, classification and result buffering. Depends on smrc_pkg,
// smrc_feed and smrc_out_buf.
//
// Usage: payload bytes come in one beat per cycle on in_valid/in_ready, each
// with frame_end and message_final marks. A result beat appears on
// out_valid/out_ready at the end of a final frame, or at the end of a frame
// in which the message reached the size limit (status 1, other fields 0).
// A result beat is registered into the result buffer. Throughput is one
// input beat per cycle while in_ready is high: the whole per-byte update
// (up to two bytes fed when a frame's held first byte is released) is
// combinational logic into the state registers. A two-entry result buffer
// decouples the sides, so input keeps flowing while one result waits;
// in_ready drops only when both entries are full. Writing cfg_wr_data = 1
// with cfg_wr_en makes every input beat be accepted and ignored until it
// is written back to 0. Synchronous reset clears the message state, the
// closing flag and the buffer; in_ready is high after reset.
module ship_message_reassembly_classifier (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  smrc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output smrc_pkg::out_beat_t out_data
);
  import smrc_pkg::*;

  typedef enum logic [1:0] {
    FB_EMPTY = 2'd0,
    FB_HELD  = 2'd1,
    FB_OPEN  = 2'd2
  } frame_cnt_t;

  logic        closing;
  logic        message_open;
  logic        message_open_next;
  frame_cnt_t  frame_cnt;
  frame_cnt_t  frame_cnt_next;
  logic [7:0]  held_byte;
  msg_state_t  msg;
  msg_state_t  msg_next;
  msg_state_t  base;
  msg_state_t  fed_first;
  msg_state_t  second_in;
  msg_state_t  fed_second;
  msg_state_t  after;
  logic        accept;
  logic        push;
  out_beat_t   push_data;

  localparam msg_state_t MSG_CLEAR = '{
    total: '0, oversize: 1'b0, type_byte: 8'd0, head_byte: 8'd0,
    phase: KP_SEEK, pos: 5'd0, mask: '1
  };

  // class of a completed message
  function automatic logic [2:0] classify(input msg_state_t m);
    logic [2:0] cls;
    cls = CLS_UNKNOWN;
    if (m.type_byte == TYPE_TERMINATE) begin
      cls = CLS_TERMINATE;
    end else if ((m.type_byte != TYPE_DATA_A && m.type_byte != TYPE_DATA_B) ||
                 m.total < CNT_W'(3)) begin
      cls = CLS_NONE;
    end else if (m.phase == KP_CLOSED && m.pos != 5'd0) begin
      // lowest matching keyword wins
      for (int k = NUM_KW - 1; k >= 0; k--) begin
        if (m.mask[k] && m.pos == KW_LEN[k]) begin
          cls = KW_CLASS[k];
        end
      end
    end
    return cls;
  endfunction

  assign accept = in_valid && in_ready;

  // held byte first, then the current byte if the limit was not hit
  assign base      = message_open ? msg : MSG_CLEAR;
  assign second_in = (frame_cnt == FB_HELD) ? fed_first : msg;
  assign after     = second_in.oversize ? second_in : fed_second;

  smrc_feed u_feed_held (
    .cur       (base),
    .data_byte (held_byte),
    .nxt       (fed_first)
  );

  smrc_feed u_feed_cur (
    .cur       (second_in),
    .data_byte (in_data.data_byte),
    .nxt       (fed_second)
  );

  // next state and result for one beat
  always_comb begin
    msg_next          = msg;
    message_open_next = message_open;
    frame_cnt_next    = frame_cnt;
    push              = 1'b0;
    push_data         = '0;
    if (frame_cnt == FB_EMPTY) begin
      frame_cnt_next = in_data.frame_end ? FB_EMPTY : FB_HELD;
    end else begin
      msg_next = after;
      if (frame_cnt == FB_HELD) begin
        message_open_next = 1'b1;
        frame_cnt_next    = FB_OPEN;
      end
      if (in_data.frame_end) begin
        frame_cnt_next = FB_EMPTY;
        if (after.oversize) begin
          msg_next.oversize = 1'b0;
          message_open_next = 1'b0;
          push              = 1'b1;
          push_data.status  = STATUS_DROPPED;
        end else if (in_data.message_final) begin
          message_open_next        = 1'b0;
          push                     = 1'b1;
          push_data.status         = STATUS_DONE;
          push_data.message_class  = classify(after);
          push_data.message_type   = after.type_byte;
          push_data.cmi_head       = after.head_byte;
          push_data.message_length = after.total[LEN_W-1:0];
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      closing      <= 1'b0;
      message_open <= 1'b0;
      frame_cnt    <= FB_EMPTY;
      held_byte    <= 8'd0;
      msg          <= MSG_CLEAR;
    end else begin
      if (cfg_wr_en) begin
        closing <= cfg_wr_data;
      end
      if (accept && !closing) begin
        message_open <= message_open_next;
        frame_cnt    <= frame_cnt_next;
        msg          <= msg_next;
        if (frame_cnt == FB_EMPTY) begin
          held_byte <= in_data.data_byte;
        end
      end
    end
  end

  smrc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && !closing && push),
    .push_data (push_data),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[dv/testbench.sv]
// Self-checking testbench for the message reassembly classifier: byte beats in, result beats out.
// Depends on smrc_pkg and ship_message_reassembly_classifier. A built-in tracker predicts every
// result, and a checker compares the results field by field under random gaps and stalls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smrc_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_BYTES  = 800;
  localparam int MAX_REPORTED  = 10;

  typedef enum logic [1:0] {FRAME_IDLE, FRAME_HELD, FRAME_TAKEN} frame_phase_t;
  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_wr_en;
  logic      cfg_wr_data;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  ship_message_reassembly_classifier dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  always #5 clk = ~clk;

  // keywords and the class each one gives
  string      kw_text [6] = '{"connectionHello", "connectionPinState", "messageHello",
                              "accessMethodsRequest", "accessMethods", "data"};
  logic [2:0] kw_cls  [6] = '{CLS_HELLO, CLS_PIN_STATE, CLS_HELLO,
                              CLS_ACCESS_REQ, CLS_ACCESS_MTH, CLS_DATA};

  // tracker state, mirrors the block
  logic         closing_q;
  logic         msg_open;
  int           msg_total;
  logic         oversize;
  logic [7:0]   type_b;
  logic [7:0]   head_b;
  logic [7:0]   held_b;
  frame_phase_t frame_ph;
  key_phase_t   key_ph;
  logic [4:0]   key_pos;
  logic [5:0]   kw_mask;

  out_beat_t  pending_reports [$];
  logic [7:0] msg_buf [$];

  int         bytes_sent;
  int         reports_due;
  int         drops_due;
  int         reports_checked;
  int         failures;
  int         cycle_count;
  logic [7:0] classes_seen;

  int          burst_left;
  int          tx_gap_max;
  logic [15:0] rx_mask = '1;
  logic [3:0]  rx_phase = '0;

  // ---------------------------------------------------------------- tracker

  task automatic tracker_reset();
    closing_q = 1'b0;
    msg_open  = 1'b0;
    msg_total = 0;
    oversize  = 1'b0;
    type_b    = '0;
    head_b    = '0;
    held_b    = '0;
    frame_ph  = FRAME_IDLE;
    key_ph    = KP_SEEK;
    key_pos   = '0;
    kw_mask   = '1;
  endtask

  // narrow the keyword candidates by one key character
  task automatic scan_key(input logic [7:0] b);
    if (key_ph == KP_SEEK) begin
      if (b == QUOTE_CHAR) begin
        key_ph  = KP_IN_KEY;
        key_pos = '0;
        kw_mask = '1;
      end
    end else if (key_ph == KP_IN_KEY) begin
      if (b == QUOTE_CHAR) begin
        key_ph = KP_CLOSED;
      end else begin
        for (int k = 0; k < 6; k++) begin
          if (key_pos >= kw_text[k].len()) kw_mask[k] = 1'b0;
          else if (8'(kw_text[k][key_pos]) != b) kw_mask[k] = 1'b0;
        end
        if (key_pos < KEY_POS_MAX) key_pos = key_pos + 5'd1;
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (msg_total == 0) begin
      type_b = b;
    end else begin
      if (msg_total == 1) head_b = b;
      scan_key(b);
    end
    msg_total++;
    if (msg_total >= MAX_MESSAGE_BYTES) oversize = 1'b1;
  endtask

  function automatic logic [2:0] message_class_of();
    if (type_b == TYPE_TERMINATE) return CLS_TERMINATE;
    if ((type_b != TYPE_DATA_A && type_b != TYPE_DATA_B) || msg_total < 3) return CLS_NONE;
    if (key_ph != KP_CLOSED || key_pos == 0) return CLS_UNKNOWN;
    for (int k = 0; k < 6; k++)
      if (kw_mask[k] && key_pos == kw_text[k].len()) return kw_cls[k];
    return CLS_UNKNOWN;
  endfunction

  // advance the tracker by one accepted beat, queue any result it causes
  task automatic track_beat(input in_beat_t beat);
    out_beat_t r;
    if (closing_q) return;
    if (frame_ph == FRAME_IDLE) begin
      held_b   = beat.data_byte;
      frame_ph = beat.frame_end ? FRAME_IDLE : FRAME_HELD;
      return;
    end
    if (frame_ph == FRAME_HELD) begin
      if (!msg_open) begin
        msg_open  = 1'b1;
        msg_total = 0;
        oversize  = 1'b0;
        type_b    = '0;
        head_b    = '0;
        key_ph    = KP_SEEK;
        key_pos   = '0;
        kw_mask   = '1;
      end
      take_byte(held_b);
      if (!oversize) take_byte(beat.data_byte);
      frame_ph = FRAME_TAKEN;
    end else if (!oversize) begin
      take_byte(beat.data_byte);
    end
    if (!beat.frame_end) return;
    frame_ph = FRAME_IDLE;
    r = '0;
    if (oversize) begin
      oversize = 1'b0;
      msg_open = 1'b0;
      r.status = STATUS_DROPPED;
      drops_due++;
    end else begin
      if (!beat.message_final) return;
      msg_open         = 1'b0;
      r.status         = STATUS_DONE;
      r.message_class  = message_class_of();
      r.message_type   = type_b;
      r.cmi_head       = head_b;
      r.message_length = LEN_W'(msg_total);
      classes_seen[r.message_class] = 1'b1;
    end
    pending_reports.push_back(r);
    reports_due++;
  endtask

  // ---------------------------------------------------------------- driving

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        tx_gap_max = 0;
        rx_mask    = '1;
      end
      IDLE_LIGHT: begin
        tx_gap_max = 2;
        rx_mask    = 16'($urandom) | 16'h8421;
      end
      default: begin
        tx_gap_max = 7;
        rx_mask    = (16'($urandom) & 16'($urandom)) | 16'h0001;
      end
    endcase
  endtask

  // send one byte beat; bursts of random length with random gaps between them
  task automatic send_byte(input logic [7:0] b, input logic fe, input logic fin);
    int       gap;
    in_beat_t beat;
    if (burst_left == 0) begin
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    beat.data_byte     = b;
    beat.frame_end     = fe;
    beat.message_final = fin;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    track_beat(beat);
    bytes_sent++;
    burst_left--;
  endtask

  // drop valid and wait for every expected result plus the pipeline tail
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_closing(input logic v);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    closing_q = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom); while (b == QUOTE_CHAR);
    return b;
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7a))
                             : 8'($urandom_range(8'h41, 8'h5a));
  endfunction

  task automatic push_text(input string s, input int n);
    for (int i = 0; i < n && i < s.len(); i++) msg_buf.push_back(8'(s[i]));
  endtask

  // chop msg_buf into frames, now and then slipping in a one-byte frame
  task automatic send_message(input int max_frame, input int short_pct);
    int idx;
    int len;
    int left;
    idx = 0;
    while (idx < msg_buf.size()) begin
      if ($urandom_range(99) < short_pct)
        send_byte(8'($urandom), 1'b1, 1'($urandom_range(1)));
      left = msg_buf.size() - idx;
      len  = $urandom_range(2, max_frame);
      if (len > left || left - len < 2) len = left;
      for (int j = 0; j < len; j++) begin
        if (j == len - 1) send_byte(msg_buf[idx + j], 1'b1, idx + len == msg_buf.size());
        else              send_byte(msg_buf[idx + j], 1'b0, 1'($urandom_range(1)));
      end
      idx += len;
    end
    msg_buf.delete();
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // mostly well-formed messages with a quoted key, some with junk or short bodies
  task automatic build_random_message();
    int pick;
    int k;
    int n;
    int at;
    msg_buf.delete();
    pick = $urandom_range(9);
    if (pick < 4)       msg_buf.push_back(TYPE_DATA_A);
    else if (pick < 7)  msg_buf.push_back(TYPE_DATA_B);
    else if (pick == 7) msg_buf.push_back(TYPE_TERMINATE);
    else if (pick == 8) msg_buf.push_back(8'($urandom));
    else                msg_buf.push_back($urandom_range(1) ? 8'h00 : 8'hff);
    msg_buf.push_back(($urandom_range(19) == 0) ? QUOTE_CHAR : 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 12) begin
      if ($urandom_range(1)) msg_buf.push_back(8'($urandom));
    end else if (pick < 27) begin
      repeat ($urandom_range(1, 20)) msg_buf.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(3)) msg_buf.push_back(rand_plain());
      msg_buf.push_back(QUOTE_CHAR);
      k = $urandom_range(5);
      n = kw_text[k].len();
      case ($urandom_range(9))
        5: push_text(kw_text[k], n - 1);
        6: begin
          at = msg_buf.size() + $urandom_range(n - 1);
          push_text(kw_text[k], n);
          msg_buf[at] = msg_buf[at] ^ 8'h20;
        end
        7: begin
          push_text(kw_text[k], n);
          msg_buf.push_back(rand_letter());
        end
        8: repeat ($urandom_range(12)) msg_buf.push_back(rand_letter());
        9: repeat ($urandom_range(28, 40)) msg_buf.push_back(rand_letter());
        default: push_text(kw_text[k], n);
      endcase
      if ($urandom_range(9) != 0) msg_buf.push_back(QUOTE_CHAR);
      repeat ($urandom_range(6)) msg_buf.push_back(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // short frames and the classes that need no key
  task automatic test_frames();
    send_byte(8'hff, 1'b1, 1'b1);
    msg_buf = '{TYPE_TERMINATE, 8'h00};
    send_message(2, 0);
    msg_buf = '{TYPE_DATA_A, 8'hff};
    send_message(2, 0);
    msg_buf = '{8'h00, QUOTE_CHAR, 8'h64, 8'h61, 8'h74, 8'h61, QUOTE_CHAR};
    send_message(7, 0);
    // head byte itself opens the key
    msg_buf = '{TYPE_DATA_B, QUOTE_CHAR, 8'h64, 8'h61, 8'h74, 8'h61, QUOTE_CHAR};
    send_message(7, 0);
    msg_buf = '{8'hff, 8'h7f, 8'h80};
    send_message(3, 0);
    // empty key, then no quote at all
    msg_buf = '{TYPE_DATA_A, 8'h00, QUOTE_CHAR, QUOTE_CHAR};
    send_message(4, 0);
    msg_buf = '{TYPE_DATA_B, 8'h41, 8'h00};
    send_message(3, 0);
    // one-byte frame in the middle of a message leaves it open
    send_byte(TYPE_DATA_A, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(QUOTE_CHAR, 1'b1, 1'b0);
    send_byte(8'h78, 1'b1, 1'b1);
    msg_buf = '{8'h64, 8'h61, 8'h74, 8'h61, QUOTE_CHAR};
    send_message(5, 0);
  endtask

  // every keyword, plus near misses and a key past the position limit
  task automatic test_keywords();
    for (int k = 0; k < 7; k++) begin
      msg_buf.push_back((k % 2) ? TYPE_DATA_B : TYPE_DATA_A);
      msg_buf.push_back(rand_plain());
      msg_buf.push_back(8'h7b);
      msg_buf.push_back(QUOTE_CHAR);
      if (k < 6) push_text(kw_text[k], kw_text[k].len());
      else       push_text("accessMethodsRequestaccessMethodsX", 40);
      msg_buf.push_back(QUOTE_CHAR);
      msg_buf.push_back(8'h3a);
      send_message(9, 0);
    end
    msg_buf = '{TYPE_DATA_A, 8'h01, QUOTE_CHAR};
    push_text("access", 6);
    msg_buf.push_back(QUOTE_CHAR);
    send_message(4, 0);
  endtask

  // input is ignored while closing, and a cut frame carries on afterwards
  task automatic test_closing();
    msg_buf = '{TYPE_DATA_B, 8'h55, QUOTE_CHAR, 8'h61, 8'h63, 8'h63};
    foreach (msg_buf[i]) send_byte(msg_buf[i], 1'b0, 1'($urandom_range(1)));
    msg_buf.delete();
    write_closing(1'b1);
    send_noise(12);
    write_closing(1'b0);
    push_text("essMethods", 10);
    msg_buf.push_back(QUOTE_CHAR);
    foreach (msg_buf[i]) send_byte(msg_buf[i], i == msg_buf.size() - 1, 1'b1);
    msg_buf.delete();
    // cut while only the first byte of a frame is held
    send_byte(TYPE_DATA_A, 1'b0, 1'b0);
    write_closing(1'b1);
    send_noise(5);
    write_closing(1'b0);
    msg_buf = '{8'h10, QUOTE_CHAR, 8'h64, 8'h61, 8'h74, 8'h61, QUOTE_CHAR};
    foreach (msg_buf[i]) send_byte(msg_buf[i], i == msg_buf.size() - 1, 1'b1);
    msg_buf.delete();
  endtask

  // largest complete message, and messages that run into the size limit
  task automatic test_size_limit();
    set_idling(IDLE_LIGHT);
    msg_buf = '{TYPE_DATA_A, 8'h02, QUOTE_CHAR, 8'h64, 8'h61, 8'h74, 8'h61, QUOTE_CHAR};
    while (msg_buf.size() < MAX_MESSAGE_BYTES - 1) msg_buf.push_back(8'($urandom));
    send_message(3000, 2);
    // limit reached exactly on the last byte of a final frame
    repeat (MAX_MESSAGE_BYTES) msg_buf.push_back(rand_plain());
    send_message(4000, 0);
    // limit reached when a frame's held first byte is released
    for (int i = 0; i < MAX_MESSAGE_BYTES - 1; i++)
      send_byte(rand_plain(), i == MAX_MESSAGE_BYTES - 2, 1'b0);
    for (int i = 0; i < 3; i++) send_byte(8'($urandom), i == 2, 1'b1);
    // limit reached mid-frame, the frames after it open a new message
    repeat (MAX_MESSAGE_BYTES + 108) msg_buf.push_back(8'($urandom));
    send_message(5000, 1);
    settle();
  endtask

  task automatic test_random();
    int first_byte;
    first_byte = bytes_sent;
    set_idling(IDLE_NONE);
    while (bytes_sent < first_byte + RANDOM_BYTES) begin
      if ($urandom_range(9) == 0) set_idling(idle_mode_t'($urandom_range(2)));
      if ($urandom_range(19) == 0) begin
        write_closing(1'b1);
        send_noise($urandom_range(1, 8));
        write_closing(1'b0);
      end
      if ($urandom_range(9) == 0) send_noise($urandom_range(1, 6));
      build_random_message();
      send_message($urandom_range(2, 12), 10);
    end
  endtask

  // ---------------------------------------------------------------- checking

  function automatic string describe(input out_beat_t r);
    return $sformatf("status %0d class %0d type %02h head %02h length %0d",
                     r.status, r.message_class, r.message_type, r.cmi_head,
                     r.message_length);
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTED) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        note_failure({"unexpected result ", describe(out_data)});
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_data.status !== want.status ||
            out_data.message_class !== want.message_class ||
            out_data.message_type !== want.message_type ||
            out_data.cmi_head !== want.cmi_head ||
            out_data.message_length !== want.message_length)
          note_failure({"expected ", describe(want), ", got ", describe(out_data)});
      end
    end
  end

  // receiver stalls on its own rotating pattern
  always @(negedge clk) begin
    out_ready <= rx_mask[rx_phase];
    rx_phase  <= rx_phase + 4'd1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    bytes_sent   = 0;
    reports_due  = 0;
    drops_due    = 0;
    reports_checked = 0;
    failures     = 0;
    cycle_count  = 0;
    classes_seen = '0;
    burst_left   = 0;
    tracker_reset();
    set_idling(IDLE_NONE);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_closing(1'b0);
    test_frames();
    set_idling(IDLE_HEAVY);
    test_keywords();
    test_closing();
    test_size_limit();
    test_random();
    settle();

    $display("sent %0d byte beats, checked %0d results (%0d dropped for size)",
             bytes_sent, reports_checked, drops_due);
    $display("message classes seen (bit per class): %b, closing toggled both ways",
             classes_seen);
    if (failures == 0 && pending_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", failures);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
